>>> hw/rtl/swfn_pkg.sv
`timescale 1ns / 1ps

package swfn_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int SAMPLE_W       = 16;
    localparam int POS_W          = 8;
    localparam int WIN_W          = 7;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [SAMPLE_W-1:0] val;
    } swfn_entry_t;

endpackage

>>> hw/rtl/sliding_window_first_negative_top.sv
`timescale 1ns / 1ps
// An accepted sample's result is held in the output register from the next cycle.
// Throughput: one sample per cycle while in_stall is low; the queue front is kept
// in registers and the next entry is prefetched every cycle from the queue memory.
// Reset clears the queue pointers, position and sample counters, and sets
// window_size to 3; queue memory contents are not cleared and need no pass.
module sliding_window_first_negative_top #(
    parameter int WINDOW_MAX = swfn_pkg::WINDOW_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [swfn_pkg::SAMPLE_W-1:0] sample,
    input  logic                            last_of_sequence,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [swfn_pkg::SAMPLE_W-1:0] first_negative,
    output logic                            found,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swfn_pkg::WIN_W-1:0]      window_size
);
    import swfn_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_MAX - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_MAX);
    localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(WINDOW_MAX);
    localparam logic [WIN_W:0]   KMAX     = (WIN_W + 1)'(WINDOW_MAX);

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
        return (a == IDX_LAST) ? '0 : IDX_W'(a + 1'b1);
    endfunction

    logic [WIN_W-1:0]    window_size_reg;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [WIN_W-1:0]    seen_reg, seen_next;
    swfn_entry_t         front_reg, front_next;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_val_reg;
    logic                found_reg;

    logic                accept;
    logic                neg;
    logic [WIN_W-1:0]    k_eff;
    logic [POS_W-1:0]    gap;
    logic                expire;
    logic                pop;
    logic [CNT_W-1:0]    cnt_pop;
    logic [CNT_W-1:0]    cnt_adv;
    logic [IDX_W-1:0]    head_adv;
    swfn_entry_t         front_adv;
    logic [WIN_W-1:0]    seen_inc;
    logic                emit;
    logic [SUM_W-1:0]    tail_sum;
    logic [IDX_W-1:0]    tail;
    swfn_entry_t         new_entry;
    swfn_entry_t         second;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;
    assign neg       = sample[SAMPLE_W-1];
    assign new_entry = '{pos: pos_reg, val: sample};

    always_comb
    begin
        if (window_size_reg == '0)
            k_eff = WIN_W'(1);
        else if ({1'b0, window_size_reg} > KMAX)
            k_eff = WIN_W'(WINDOW_MAX);
        else
            k_eff = window_size_reg;
    end

    assign gap      = pos_reg - front_reg.pos;
    assign expire   = (count_reg != '0) && (gap >= {1'b0, k_eff});
    assign pop      = expire || (neg && (count_reg == CNT_FULL));
    assign cnt_pop  = count_reg - CNT_W'(pop);
    assign cnt_adv  = cnt_pop + CNT_W'(neg);
    assign head_adv = pop ? idx_inc(head_reg) : head_reg;

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail     = (tail_sum >= SUM_MAX) ? IDX_W'(tail_sum - SUM_MAX) : IDX_W'(tail_sum);

    always_comb
    begin
        front_adv = front_reg;
        if (pop)
        begin
            if (cnt_pop != '0)
                front_adv = second;
            else if (neg)
                front_adv = new_entry;
        end
        else if ((count_reg == '0) && neg)
        begin
            front_adv = new_entry;
        end
    end

    assign seen_inc = (seen_reg < k_eff) ? WIN_W'(seen_reg + 1'b1) : seen_reg;
    assign emit     = (seen_inc >= k_eff);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        front_next = front_reg;
        if (accept)
        begin
            front_next = front_adv;
            if (last_of_sequence)
            begin
                head_next  = '0;
                count_next = '0;
                pos_next   = '0;
                seen_next  = '0;
            end
            else
            begin
                head_next  = head_adv;
                count_next = cnt_adv;
                pos_next   = POS_W'(pos_reg + 1'b1);
                seen_next  = seen_inc;
            end
        end
    end

    swfn_queue_mem #(
        .DEPTH (WINDOW_MAX),
        .IDX_W (IDX_W)
    ) u_queue_mem (
        .clk     (clk),
        .wr_en   (accept && neg),
        .wr_addr (tail),
        .wr_data (new_entry),
        .rd_addr (idx_inc(head_next)),
        .rd_data (second)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_RESET;
            head_reg        <= '0;
            count_reg       <= '0;
            pos_reg         <= '0;
            seen_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                window_size_reg <= window_size;
            head_reg  <= head_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
            if (accept && emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        if (accept && emit)
        begin
            found_reg   <= (cnt_adv != '0);
            out_val_reg <= (cnt_adv != '0) ? front_adv.val : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign first_negative = out_val_reg;
    assign found          = found_reg;

endmodule

>>> hw/rtl/swfn_queue_mem.sv
`timescale 1ns / 1ps

module swfn_queue_mem #(
    parameter int DEPTH = swfn_pkg::WINDOW_MAX_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  swfn_pkg::swfn_entry_t wr_data,
    input  logic [IDX_W-1:0]    rd_addr,
    output swfn_pkg::swfn_entry_t rd_data
);
    import swfn_pkg::*;

    swfn_entry_t mem [DEPTH];
    swfn_entry_t rd_reg;
    swfn_entry_t fwd_data_reg;
    logic        fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg       <= mem[rd_addr];
        fwd_reg      <= wr_en && (wr_addr == rd_addr);
        fwd_data_reg <= wr_data;
    end

    // bypass a write that lands on the entry being read
    assign rd_data = fwd_reg ? fwd_data_reg : rd_reg;

endmodule
